@@ hw/rtl/rgbhs_pkg.sv @@
// Package: constants, types and the divider step for the RGB to hue/saturation block.
package rgbhs_pkg;

  // Hue wheel bases per dominant channel and span of one sector
  localparam logic [7:0] HUE_BASE_RED   = 8'd0;
  localparam logic [7:0] HUE_BASE_GREEN = 8'd85;
  localparam logic [7:0] HUE_BASE_BLUE  = 8'd171;
  localparam logic [5:0] HUE_SPAN       = 6'd43;

  // Divider stages: saturation quotient bits, hue quotient bits
  localparam int SAT_STEPS = 8;
  localparam int HUE_STEPS = 6;

  // One word moving through the divider stages
  typedef struct packed {
    logic [7:0] srem;   // saturation partial remainder
    logic [7:0] snum;   // saturation dividend bits still to shift in
    logic [7:0] sq;     // saturation quotient bits so far
    logic [7:0] mx;     // saturation divisor
    logic [7:0] hrem;   // hue partial remainder
    logic [5:0] hnum;   // hue dividend bits still to shift in
    logic [5:0] hq;     // hue quotient bits so far
    logic [7:0] d;      // hue divisor (max - min)
    logic [7:0] base;   // hue base of the dominant channel
    logic       neg;    // hue offset is negative
    logic       zero;   // gray pixel: hue and saturation forced to zero
  } div_t;

  typedef struct packed {
    logic       q;
    logic [7:0] rem;
  } step_t;

  // One restoring division step; the remainder in is below the divisor
  function automatic step_t div_step(input logic [7:0] rem, input logic nbit,
                                     input logic [7:0] den);
    logic [8:0] t;
    logic [8:0] diff;
    step_t      s;
    t    = {rem, nbit};
    diff = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      s.q   = 1'b1;
      s.rem = diff[7:0];
    end else begin
      s.q   = 1'b0;
      s.rem = t[7:0];
    end
    return s;
  endfunction

endpackage

@@ hw/rtl/rgbhs_pixel_if.sv @@
// Interfaces: RGB pixel channel and hue/saturation result channel.
interface rgbhs_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhs_hs_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] saturation;

  modport source (output valid, output hue, output saturation, input ready);
  modport sink   (input valid, input hue, input saturation, output ready);
endinterface

@@ hw/rtl/rgb_to_hue_saturation.sv @@
// Top level: pipelined conversion of an 8-bit RGB pixel to 8-bit hue and saturation.
//
// Takes one pixel word per clock when the output side does not stall and returns one
// hue/saturation word per pixel, in order. The rate of one word per cycle comes from
// a 12-stage pipeline: input register, max/min and sector select, the two constant
// multiplies, eight stages of a restoring divider (one quotient bit each for
// saturation, and for the first six also for hue, run side by side), and the output
// register. When the output word is not taken the whole pipeline holds, so pixel.ready
// follows result.ready whenever the output register is full. Hue is 0 and saturation
// is 0 for gray and black pixels; hue wraps modulo 256.
module rgb_to_hue_saturation
  import rgbhs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  rgbhs_pixel_if.sink pixel,
  rgbhs_hs_if.source  result
);

  logic advance;

  // Stage A: input pixel
  logic       va;
  logic [7:0] ra, ga, ba;

  // Stage B: extremes, sector, offset magnitude
  logic       vb;
  logic [7:0] mxb, db, diffb, baseb;
  logic       negb;

  // Divider pipeline; entry 0 is loaded by the multiply stage
  logic  dv [0:SAT_STEPS];
  div_t  dp [0:SAT_STEPS];
  div_t  dnext [0:SAT_STEPS-1];

  // Output register
  logic       ov;
  logic [7:0] hue_r, sat_r;

  // Global hold while the output word waits
  assign advance     = !ov || result.ready;
  assign pixel.ready = advance;

  // Stage A register
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (advance) begin
      va <= pixel.valid;
    end
    if (advance) begin
      ra <= pixel.red;
      ga <= pixel.green;
      ba <= pixel.blue;
    end
  end

  // Stage B: max, min, dominant channel and signed offset of the other two
  logic [7:0] mx_c, mn_c, a_c, b_c, base_c;

  always_comb begin
    mx_c = ra;
    mn_c = ra;
    if (ga > mx_c) mx_c = ga;
    if (ba > mx_c) mx_c = ba;
    if (ga < mn_c) mn_c = ga;
    if (ba < mn_c) mn_c = ba;
    if (mx_c == ra) begin
      base_c = HUE_BASE_RED;
      a_c    = ga;
      b_c    = ba;
    end else if (mx_c == ga) begin
      base_c = HUE_BASE_GREEN;
      a_c    = ba;
      b_c    = ra;
    end else begin
      base_c = HUE_BASE_BLUE;
      a_c    = ra;
      b_c    = ga;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (advance) begin
      vb <= va;
    end
    if (advance) begin
      mxb   <= mx_c;
      db    <= mx_c - mn_c;
      baseb <= base_c;
      negb  <= (a_c < b_c);
      diffb <= (a_c < b_c) ? (b_c - a_c) : (a_c - b_c);
    end
  end

  // Stage C: hue dividend 43*offset, saturation dividend d*255
  logic [13:0] hprod;
  logic [15:0] sprod;

  assign hprod = 14'(diffb) * 14'(HUE_SPAN);
  assign sprod = {db, 8'd0} - 16'(db);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (advance) begin
      dv[0] <= vb;
    end
    if (advance) begin
      dp[0].srem <= sprod[15:8];
      dp[0].snum <= sprod[7:0];
      dp[0].sq   <= '0;
      dp[0].mx   <= mxb;
      dp[0].hrem <= hprod[13:6];
      dp[0].hnum <= hprod[5:0];
      dp[0].hq   <= '0;
      dp[0].d    <= db;
      dp[0].base <= baseb;
      dp[0].neg  <= negb;
      dp[0].zero <= (db == 8'd0);
    end
  end

  // Divider stages: one saturation quotient bit per stage, one hue bit in each of the first HUE_STEPS
  always_comb begin
    step_t ss;
    step_t hs;
    for (int i = 0; i < SAT_STEPS; i++) begin
      dnext[i] = dp[i];
      ss = div_step(dp[i].srem, dp[i].snum[7], dp[i].mx);
      dnext[i].srem = ss.rem;
      dnext[i].snum = {dp[i].snum[6:0], 1'b0};
      dnext[i].sq   = {dp[i].sq[6:0], ss.q};
      if (i < HUE_STEPS) begin
        hs = div_step(dp[i].hrem, dp[i].hnum[5], dp[i].d);
        dnext[i].hrem = hs.rem;
        dnext[i].hnum = {dp[i].hnum[4:0], 1'b0};
        dnext[i].hq   = {dp[i].hq[4:0], hs.q};
      end
    end
  end

  for (genvar i = 0; i < SAT_STEPS; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1] <= 1'b0;
      end else if (advance) begin
        dv[i+1] <= dv[i];
      end
      if (advance) begin
        dp[i+1] <= dnext[i];
      end
    end
  end

  // Output stage: apply base and sign, force gray pixels to zero
  logic [7:0] hue_c, sat_c;

  always_comb begin
    if (dp[SAT_STEPS].zero) begin
      hue_c = 8'd0;
      sat_c = 8'd0;
    end else begin
      sat_c = dp[SAT_STEPS].sq;
      if (dp[SAT_STEPS].neg) begin
        hue_c = dp[SAT_STEPS].base - {2'b00, dp[SAT_STEPS].hq};
      end else begin
        hue_c = dp[SAT_STEPS].base + {2'b00, dp[SAT_STEPS].hq};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (advance) begin
      ov <= dv[SAT_STEPS];
    end
    if (advance) begin
      hue_r <= hue_c;
      sat_r <= sat_c;
    end
  end

  assign result.valid      = ov;
  assign result.hue        = hue_r;
  assign result.saturation = sat_r;

  // Divider entry: partial remainders start below their divisors
  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    dv[0] && !dp[0].zero |-> (dp[0].srem < dp[0].mx) && (dp[0].hrem < dp[0].d))
    else $error("divider entry remainder not below divisor");

  // Hue offset never exceeds one sector
  a_hue_span: assert property (@(posedge clk) disable iff (rst)
    dv[SAT_STEPS] && !dp[SAT_STEPS].zero |-> dp[SAT_STEPS].hq <= HUE_SPAN)
    else $error("hue quotient beyond sector span");

  // A held pipeline keeps the word in divider stage HUE_STEPS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(dv[HUE_STEPS]) && $stable(dp[HUE_STEPS]))
    else $error("divider stage changed during stall");

  // A black pixel (max of zero) has a zero difference, so it is zero-forced like a gray one
  a_gray: assert property (@(posedge clk) disable iff (rst)
    vb && (mxb == 8'd0) |-> (db == 8'd0))
    else $error("black pixel with nonzero difference");

endmodule
